### rtl/qph_pkg.sv
// Shared types and constants for the quadratic probing hash table.
package qph_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int KEY_BITS_DEF   = 32;

    localparam int KIND_W      = 2;
    localparam int KEY_W       = 32;
    localparam int HASH_W      = 32;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int SLOT_OUT_W  = 8;
    localparam int COUNT_OUT_W = 9;
    localparam int MARK_W      = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;

    localparam logic [MARK_W-1:0] MARK_EMPTY    = 2'd0;
    localparam logic [MARK_W-1:0] MARK_OCCUPIED = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   key;
        logic [HASH_W-1:0]  hash;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [VALUE_W-1:0]     value_out;
        logic [SLOT_OUT_W-1:0]  slot_index;
        logic [COUNT_OUT_W-1:0] element_count;
    } rsp_t;

endpackage

### rtl/qph_mod.sv
// Reduction of the hash modulo the table size by multiplication with a fixed reciprocal.
module qph_mod import qph_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [HASH_W-1:0]             hash,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] home
);

    localparam int AW      = $clog2(TABLE_SIZE);
    localparam int RECIP_W = HASH_W + 1;
    localparam int LO_W    = 16;
    localparam int HI_W    = RECIP_W - LO_W;
    localparam int PLO_W   = HASH_W + LO_W;
    localparam int PHI_W   = HASH_W + HI_W;
    localparam int PROD_W  = HASH_W + RECIP_W;

    // Rounding the reciprocal up keeps the quotient exact for every hash value, because the
    // table size never exceeds two to the power AW.
    localparam logic [63:0]     RECIP    = ((64'd1 << (HASH_W + AW)) / 64'(TABLE_SIZE)) + 64'd1;
    localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
    localparam logic [HI_W-1:0] RECIP_HI = RECIP[RECIP_W-1:LO_W];
    localparam logic [AW-1:0]   SIZE_LOW = AW'(TABLE_SIZE);

    logic [3:0]        stage_reg, stage_next;
    logic [HASH_W-1:0] hash_reg;
    logic [PLO_W-1:0]  prod_lo_reg, prod_lo_next;
    logic [PHI_W-1:0]  prod_hi_reg, prod_hi_next;
    logic [PROD_W-1:0] prod_sum;
    logic [HASH_W-1:0] quot_reg, quot_next;
    logic [AW-1:0]     home_reg, home_next;

    always_comb
    begin
        stage_next   = {stage_reg[2:0], start};
        prod_lo_next = PLO_W'(hash_reg) * PLO_W'(RECIP_LO);
        prod_hi_next = PHI_W'(hash_reg) * PHI_W'(RECIP_HI);
        prod_sum     = {prod_hi_reg, LO_W'(0)} + PROD_W'(prod_lo_reg);
        quot_next    = HASH_W'(prod_sum >> (HASH_W + AW));
        // The remainder is below the table size, so its low AW bits are all that is needed.
        home_next    = hash_reg[AW-1:0] - AW'(quot_reg[AW-1:0] * SIZE_LOW);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            hash_reg <= hash;
        if (stage_reg[0])
        begin
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
        end
        if (stage_reg[1])
            quot_reg <= quot_next;
        if (stage_reg[2])
            home_reg <= home_next;
    end

    assign done = stage_reg[3];
    assign home = home_reg;

endmodule

### rtl/qph_mem.sv
// Slot memory with a registered read and a clearing pass after reset.
module qph_mem import qph_pkg::*; #(
    parameter int DEPTH  = TABLE_SIZE_DEF,
    parameter int DATA_W = MARK_W + KEY_W + VALUE_W
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    output logic                     clr_busy
);

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              clr_busy_reg, clr_busy_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic              we;
    logic [AW-1:0]     wa;
    logic [DATA_W-1:0] wd;

    // An all-zero word marks a slot empty.
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
                clr_busy_next = 1'b0;
        end
        we = clr_busy_reg | wr_en;
        wa = clr_busy_reg ? clr_addr_reg : wr_addr;
        wd = clr_busy_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

### rtl/quadratic_probe_hash_table_unit.sv
// Open-addressed hash table with quadratic probing. After reset the block clears the slot
// memory and takes no request during that time. A request then has its hash reduced modulo
// the table size by a reciprocal multiplication, which registers the hash, the two partial
// products, the quotient and the remainder in turn; the probed slots follow, then the last
// registered read and the hand-over of the result. A miss walks the whole probe sequence.
// The next request is taken in the cycle after the result is handed over. The single read
// port of the slot memory, one probe per cycle, sets the probe rate. One request is worked
// on at a time; a new one is taken while the previous result still waits in the output
// register, and a finished result that finds that register still full waits until it is
// taken.
module quadratic_probe_hash_table_unit import qph_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int AW     = $clog2(TABLE_SIZE);
    localparam int CW     = $clog2(TABLE_SIZE + 1);
    localparam int KW     = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int DW     = MARK_W + KW + VALUE_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HASH  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [KW-1:0]      key_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [AW:0]        issue_cnt_reg, issue_cnt_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW-1:0]      step_reg, step_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_slot_reg;
    logic [CW-1:0]      count_reg, count_next;
    rsp_t               res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg;

    logic               accept;
    logic               mod_done;
    logic [AW-1:0]      home;
    logic               clr_busy;
    logic               rd_en;
    logic [DW-1:0]      rd_data;
    logic               wr_en;
    logic [DW-1:0]      wr_data;

    logic [MARK_W-1:0]  s_mark;
    logic [KW-1:0]      s_key;
    logic [VALUE_W-1:0] s_val;
    logic               occupied, key_eq, is_insert, hit, miss_end, issue;
    logic [AW:0]        addr_sum, step_sum;

    assign accept = req_valid && req_ready;

    qph_mod #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .hash     (req.hash),
        .done     (mod_done),
        .home     (home)
    );

    qph_mem #(
        .DEPTH  (TABLE_SIZE),
        .DATA_W (DW)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (addr_reg),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (pend_slot_reg),
        .wr_data  (wr_data),
        .clr_busy (clr_busy)
    );

    always_comb
    begin
        s_mark    = rd_data[DW-1 -: MARK_W];
        s_key     = rd_data[VALUE_W +: KW];
        s_val     = rd_data[VALUE_W-1:0];
        occupied  = (s_mark == MARK_OCCUPIED);
        key_eq    = (s_key == key_reg);
        is_insert = (kind_reg == KIND_INSERT);
        // Insert stops at any slot that is not occupied or holds its key; lookups need a live matching key.
        hit       = pend_reg && (is_insert ? (!occupied || key_eq) : (occupied && key_eq));
        miss_end  = pend_reg && !hit && (issue_cnt_reg == (AW+1)'(TABLE_SIZE));
        issue     = (state_reg == S_PROBE) && !hit
                    && (issue_cnt_reg != (AW+1)'(TABLE_SIZE));

        // Next probe offset: the step between squares runs through the odd numbers.
        addr_sum = {1'b0, addr_reg} + {1'b0, step_reg};
        step_sum = {1'b0, step_reg} + (AW+1)'(2);
    end

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        addr_next      = addr_reg;
        step_next      = step_reg;
        pend_next      = 1'b0;
        count_next     = count_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        rd_en          = issue;
        wr_en          = 1'b0;
        wr_data        = {MARK_OCCUPIED, key_reg, val_reg};

        if (rsp_valid && rsp_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_HASH;
            end
            S_HASH:
            begin
                if (mod_done)
                begin
                    addr_next      = home;
                    step_next      = AW'(1);
                    issue_cnt_next = '0;
                    state_next     = S_PROBE;
                end
            end
            S_PROBE:
            begin
                pend_next = issue;
                if (issue)
                begin
                    issue_cnt_next = issue_cnt_reg + (AW+1)'(1);
                    if (addr_sum >= (AW+1)'(TABLE_SIZE))
                        addr_next = AW'(addr_sum - (AW+1)'(TABLE_SIZE));
                    else
                        addr_next = AW'(addr_sum);
                    if (step_sum >= (AW+1)'(TABLE_SIZE))
                        step_next = AW'(step_sum - (AW+1)'(TABLE_SIZE));
                    else
                        step_next = AW'(step_sum);
                end
                if (hit)
                begin
                    res_next.slot_index = SLOT_OUT_W'(pend_slot_reg);
                    res_next.value_out  = '0;
                    if (is_insert)
                    begin
                        if (!occupied)
                        begin
                            wr_en           = 1'b1;
                            count_next      = count_reg + CW'(1);
                            res_next.status = ST_INSERTED;
                        end
                        else
                            res_next.status = ST_DUPLICATE;
                    end
                    else
                    begin
                        res_next.value_out = s_val;
                        if (kind_reg == KIND_DELETE)
                        begin
                            wr_en           = 1'b1;
                            wr_data         = {MARK_DELETED, s_key, s_val};
                            count_next      = count_reg - CW'(1);
                            res_next.status = ST_DELETED;
                        end
                        else
                            res_next.status = ST_FOUND;
                    end
                    state_next = S_DONE;
                end
                else if (miss_end)
                begin
                    res_next.status     = is_insert ? ST_FULL : ST_NOT_FOUND;
                    res_next.value_out  = '0;
                    res_next.slot_index = '0;
                    state_next          = S_DONE;
                end
                res_next.element_count = COUNT_OUT_W'(count_next);
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= req.kind;
            key_reg  <= KW'(req.key);
            val_reg  <= req.value;
        end
        addr_reg      <= addr_next;
        step_reg      <= step_next;
        pend_slot_reg <= addr_reg;
        res_reg       <= res_next;
        if (state_reg == S_DONE && (!out_valid_reg || rsp_ready))
            out_reg <= res_reg;
    end

    assign req_ready = (state_reg == S_IDLE) && !clr_busy;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
